/* hw/rtl/dssq_pkg.sv */
`default_nettype none

package dssq_pkg;

    localparam int IDX_W     = 9;
    localparam int RING_SIZE = 1 << IDX_W;

    localparam logic [IDX_W-1:0] ID_MAX = IDX_W'(RING_SIZE - 2);

    localparam int CMD_W       = 3;
    localparam int S_TDATA_W   = 24;
    localparam int M_TDATA_W   = 24;

    localparam int IN_CMD_LSB  = 0;
    localparam int IN_ELEM_LSB = IN_CMD_LSB + CMD_W;
    localparam int IN_FILL_LSB = IN_ELEM_LSB + IDX_W;

    localparam int OUT_OK_BIT    = 0;
    localparam int OUT_ELEM_LSB  = 1;
    localparam int OUT_COUNT_LSB = OUT_ELEM_LSB + IDX_W;
    localparam int OUT_EMPTY_BIT = OUT_COUNT_LSB + IDX_W;
    localparam int OUT_ERR_BIT   = OUT_EMPTY_BIT + 1;
    localparam int OUT_PAD_W     = M_TDATA_W - OUT_ERR_BIT - 1;

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD,
        CMD_REMOVE,
        CMD_QUERY,
        CMD_TAKE_FRONT,
        CMD_TAKE_BACK,
        CMD_CLEAR,
        CMD_FILL_ASC,
        CMD_FILL_DESC
    } cmd_t;

endpackage

`default_nettype wire

/* hw/rtl/dedup_sparse_set_work_queue_unit.sv */
// Channel | Direction | Signals                    | Payload
// s_      | in        | s_tvalid s_tready s_tdata  | cmd, element, fill_count
// m_      | out       | m_tvalid m_tready m_tdata  | ok, element_out, count, empty_res,
//         |           |                            | range_error
// Add, remove, query, take and clear step through accept with position lookup,
// ring lookup, then write-back and result. The dependent position-then-ring read
// through the two memories with registered reads sets this order.
// Fill writes one ring and one position entry per loaded id.
// Reset clears head, tail and the control state, then sweeps every entry of both
// memories to zero with s_tready held low.
// A held result stalls the final step until the output register is free.
`default_nettype none

module dedup_sparse_set_work_queue_unit (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // cmd[2:0], element[11:3], fill_count[20:12], zero pad
    input  wire logic [dssq_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // ok[0], element_out[9:1], count[18:10], empty_res[19], range_error[20], zero pad
    output logic [dssq_pkg::M_TDATA_W-1:0]      m_tdata
);

    localparam int W = dssq_pkg::IDX_W;

    typedef enum logic [2:0] {
        ST_SWEEP,
        ST_IDLE,
        ST_LOOK,
        ST_DECIDE,
        ST_FILL
    } state_t;

    state_t         state_reg, state_next;
    dssq_pkg::cmd_t cmd_reg, cmd_next;
    logic [W-1:0]   elem_reg, elem_next;
    logic [W-1:0]   n_reg, n_next;
    logic [W-1:0]   head_reg, head_next;
    logic [W-1:0]   tail_reg, tail_next;
    logic [W-1:0]   fill_idx_reg, fill_idx_next;
    logic           m_tvalid_reg, m_tvalid_next;
    logic [dssq_pkg::M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    logic [W-1:0] pos_mem   [dssq_pkg::RING_SIZE];
    logic [W-1:0] dense_mem [dssq_pkg::RING_SIZE];
    logic [W-1:0] pos_rd_reg;
    logic [W-1:0] dense_a_reg;
    logic [W-1:0] dense_b_reg;

    logic         pos_we, dense_we;
    logic [W-1:0] pos_waddr, pos_wdata, dense_waddr, dense_wdata;
    logic [W-1:0] dense_a_addr;

    logic           s_acc;
    dssq_pkg::cmd_t s_cmd;
    logic [W-1:0]   s_elem, s_n;

    logic [W-1:0] tail_dec, live, slot_off, fill_val, cnt;
    logic         member, id_err, n_err, out_free, fill_last, finish;
    logic         res_ok, res_err;
    logic [W-1:0] res_elem;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_acc    = s_tvalid && s_tready;
    assign s_cmd    = dssq_pkg::cmd_t'(s_tdata[dssq_pkg::IN_CMD_LSB +: dssq_pkg::CMD_W]);
    assign s_elem   = s_tdata[dssq_pkg::IN_ELEM_LSB +: W];
    assign s_n      = s_tdata[dssq_pkg::IN_FILL_LSB +: W];

    assign tail_dec  = tail_reg - W'(1);
    assign live      = tail_reg - head_reg;
    assign slot_off  = pos_rd_reg - head_reg;
    assign member    = (slot_off < live) && (dense_a_reg == elem_reg);
    assign id_err    = elem_reg > dssq_pkg::ID_MAX;
    assign n_err     = n_reg > dssq_pkg::ID_MAX;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign fill_last = (fill_idx_reg == n_reg - W'(1));
    assign fill_val  = (cmd_reg == dssq_pkg::CMD_FILL_ASC) ? fill_idx_reg
                                                          : n_reg - fill_idx_reg - W'(1);
    assign dense_a_addr = (cmd_reg == dssq_pkg::CMD_TAKE_FRONT) ? head_reg : pos_rd_reg;

    // position memory: one read, one write
    always_ff @(posedge aclk) begin
        if (s_acc) begin
            pos_rd_reg <= pos_mem[s_elem];
        end
        if (pos_we) begin
            pos_mem[pos_waddr] <= pos_wdata;
        end
    end

    // ring memory: two reads, one write
    always_ff @(posedge aclk) begin
        if (state_reg == ST_LOOK) begin
            dense_a_reg <= dense_mem[dense_a_addr];
            dense_b_reg <= dense_mem[tail_dec];
        end
        if (dense_we) begin
            dense_mem[dense_waddr] <= dense_wdata;
        end
    end

    always_comb begin
        state_next    = state_reg;
        cmd_next      = cmd_reg;
        elem_next     = elem_reg;
        n_next        = n_reg;
        head_next     = head_reg;
        tail_next     = tail_reg;
        fill_idx_next = fill_idx_reg;
        pos_we        = 1'b0;
        pos_waddr     = '0;
        pos_wdata     = '0;
        dense_we      = 1'b0;
        dense_waddr   = '0;
        dense_wdata   = '0;
        res_ok        = 1'b0;
        res_err       = 1'b0;
        res_elem      = '0;
        finish        = 1'b0;

        unique case (state_reg)
            ST_SWEEP: begin
                pos_we        = 1'b1;
                pos_waddr     = fill_idx_reg;
                dense_we      = 1'b1;
                dense_waddr   = fill_idx_reg;
                fill_idx_next = fill_idx_reg + W'(1);
                if (fill_idx_reg == '1) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_acc) begin
                    cmd_next   = s_cmd;
                    elem_next  = s_elem;
                    n_next     = s_n;
                    state_next = ST_LOOK;
                end
            end
            ST_LOOK: begin
                state_next = ST_DECIDE;
            end
            ST_DECIDE: begin
                if (out_free) begin
                    finish = 1'b1;
                    unique case (cmd_reg)
                        dssq_pkg::CMD_ADD: begin
                            if (id_err) begin
                                res_err = 1'b1;
                            end else if (!member) begin
                                pos_we      = 1'b1;
                                pos_waddr   = elem_reg;
                                pos_wdata   = tail_reg;
                                dense_we    = 1'b1;
                                dense_waddr = tail_reg;
                                dense_wdata = elem_reg;
                                tail_next   = tail_reg + W'(1);
                                res_ok      = 1'b1;
                            end
                        end
                        dssq_pkg::CMD_REMOVE: begin
                            if (id_err) begin
                                res_err = 1'b1;
                            end else if (member) begin
                                dense_we    = 1'b1;
                                dense_waddr = pos_rd_reg;
                                dense_wdata = dense_b_reg;
                                pos_we      = 1'b1;
                                pos_waddr   = dense_b_reg;
                                pos_wdata   = pos_rd_reg;
                                tail_next   = tail_dec;
                                res_ok      = 1'b1;
                            end
                        end
                        dssq_pkg::CMD_QUERY: begin
                            res_err = id_err;
                            res_ok  = !id_err && member;
                        end
                        dssq_pkg::CMD_TAKE_FRONT: begin
                            if (live != '0) begin
                                res_elem  = dense_a_reg;
                                head_next = head_reg + W'(1);
                                res_ok    = 1'b1;
                            end
                        end
                        dssq_pkg::CMD_TAKE_BACK: begin
                            if (live != '0) begin
                                res_elem  = dense_b_reg;
                                tail_next = tail_dec;
                                res_ok    = 1'b1;
                            end
                        end
                        dssq_pkg::CMD_CLEAR: begin
                            head_next = '0;
                            tail_next = '0;
                        end
                        dssq_pkg::CMD_FILL_ASC, dssq_pkg::CMD_FILL_DESC: begin
                            if (n_err) begin
                                res_err = 1'b1;
                            end else if (n_reg == '0) begin
                                head_next = '0;
                                tail_next = '0;
                            end else begin
                                finish        = 1'b0;
                                fill_idx_next = '0;
                                state_next    = ST_FILL;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_FILL: begin
                if (!fill_last || out_free) begin
                    dense_we      = 1'b1;
                    dense_waddr   = fill_idx_reg;
                    dense_wdata   = fill_val;
                    pos_we        = 1'b1;
                    pos_waddr     = fill_val;
                    pos_wdata     = fill_idx_reg;
                    fill_idx_next = fill_idx_reg + W'(1);
                    if (fill_last) begin
                        head_next = '0;
                        tail_next = n_reg;
                        finish    = 1'b1;
                    end
                end
            end
            default: ;
        endcase

        cnt = tail_next - head_next;

        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        if (finish) begin
            state_next    = ST_IDLE;
            m_tvalid_next = 1'b1;
            m_tdata_next  = {{dssq_pkg::OUT_PAD_W{1'b0}}, res_err, (cnt == '0), cnt,
                             res_elem, res_ok};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_SWEEP;
            head_reg     <= '0;
            tail_reg     <= '0;
            fill_idx_reg <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            head_reg     <= head_next;
            tail_reg     <= tail_next;
            fill_idx_reg <= fill_idx_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        cmd_reg      <= cmd_next;
        elem_reg     <= elem_next;
        n_reg        <= n_next;
        m_tdata_reg  <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

`default_nettype wire

/* hw/rtl/dssq_checker.sv */
`default_nettype none

module dssq_checker (
    input wire logic                           aclk,
    input wire logic                           aresetn,
    input wire logic                           s_tvalid,
    input wire logic                           s_tready,
    input wire logic                           m_tvalid,
    input wire logic                           m_tready,
    input wire logic [dssq_pkg::M_TDATA_W-1:0] m_tdata
);

    logic                      out_ok, out_empty, out_err;
    logic [dssq_pkg::IDX_W-1:0] out_elem, out_count;

    assign out_ok    = m_tdata[dssq_pkg::OUT_OK_BIT];
    assign out_elem  = m_tdata[dssq_pkg::OUT_ELEM_LSB +: dssq_pkg::IDX_W];
    assign out_count = m_tdata[dssq_pkg::OUT_COUNT_LSB +: dssq_pkg::IDX_W];
    assign out_empty = m_tdata[dssq_pkg::OUT_EMPTY_BIT];
    assign out_err   = m_tdata[dssq_pkg::OUT_ERR_BIT];

    a_reset_idle: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result transfer pending after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    a_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (out_empty == (out_count == '0)))
        else $error("empty flag disagrees with count");

    a_err_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && out_err |-> !out_ok && (out_elem == '0))
        else $error("rejected command reports success");

    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input transfer taken while a command is in progress");

endmodule

bind dedup_sparse_set_work_queue_unit dssq_checker u_dssq_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

/* bench/dedup_sparse_set_work_queue_unit_tb.sv */
module dedup_sparse_set_work_queue_unit_tb;

    localparam int W = dssq_pkg::IDX_W;

    typedef struct packed {
        logic         ok;
        logic [W-1:0] element_out;
        logic [W-1:0] count;
        logic         empty_res;
        logic         range_error;
    } queue_result_t;

    logic                           aclk     = 1'b0;
    logic                           aresetn  = 1'b0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [dssq_pkg::S_TDATA_W-1:0] s_tdata  = '0;
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [dssq_pkg::M_TDATA_W-1:0] m_tdata;

    logic [W-1:0] ring_slots [dssq_pkg::RING_SIZE] = '{default: '0};
    logic [W-1:0] slot_of    [dssq_pkg::RING_SIZE] = '{default: '0};
    logic [W-1:0] front_idx = '0;
    logic [W-1:0] back_idx  = '0;
    logic [W-1:0] last_taken = '0;

    queue_result_t pending_results [$];

    int send_idle_pct    = 0;
    int stall_pct        = 0;
    int commands_sent    = 0;
    int results_checked  = 0;
    int ok_results       = 0;
    int range_errors     = 0;
    int error_count      = 0;

    dedup_sparse_set_work_queue_unit u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("MISMATCH at result %0d, %s: got %0d, expected %0d",
                 results_checked, what, got, want);
        error_count++;
    endtask

    function automatic logic id_is_queued(input logic [W-1:0] id);
        logic [W-1:0] slot;
        logic [W-1:0] offset;
        logic [W-1:0] live;
        slot   = slot_of[id];
        offset = slot - front_idx;
        live   = back_idx - front_idx;
        return (offset < live) && (ring_slots[slot] == id);
    endfunction

    task automatic apply_queue_command(input dssq_pkg::cmd_t cmd, input logic [W-1:0] id,
                                       input logic [W-1:0] n,
                                       output queue_result_t res);
        logic [W-1:0] hole;
        logic [W-1:0] last;
        logic [W-1:0] fill_pos;
        logic [W-1:0] fill_id;
        res = '0;
        case (cmd)
            dssq_pkg::CMD_ADD, dssq_pkg::CMD_REMOVE, dssq_pkg::CMD_QUERY: begin
                if (id > dssq_pkg::ID_MAX) begin
                    res.range_error = 1'b1;
                end else if (cmd == dssq_pkg::CMD_ADD) begin
                    if (!id_is_queued(id)) begin
                        slot_of[id]          = back_idx;
                        ring_slots[back_idx] = id;
                        back_idx++;
                        res.ok = 1'b1;
                    end
                end else if (cmd == dssq_pkg::CMD_REMOVE) begin
                    if (id_is_queued(id)) begin
                        hole = slot_of[id];
                        back_idx--;
                        last                 = ring_slots[back_idx];
                        ring_slots[hole]     = last;
                        slot_of[last]        = hole;
                        ring_slots[back_idx] = id;
                        res.ok = 1'b1;
                    end
                end else begin
                    res.ok = id_is_queued(id);
                end
            end
            dssq_pkg::CMD_TAKE_FRONT: begin
                if (front_idx != back_idx) begin
                    res.element_out = ring_slots[front_idx];
                    front_idx++;
                    res.ok = 1'b1;
                end
            end
            dssq_pkg::CMD_TAKE_BACK: begin
                if (front_idx != back_idx) begin
                    back_idx--;
                    res.element_out = ring_slots[back_idx];
                    res.ok = 1'b1;
                end
            end
            dssq_pkg::CMD_CLEAR: begin
                front_idx = '0;
                back_idx  = '0;
            end
            default: begin
                if (n > dssq_pkg::ID_MAX) begin
                    res.range_error = 1'b1;
                end else begin
                    for (fill_pos = '0; fill_pos < n; fill_pos++) begin
                        fill_id = (cmd == dssq_pkg::CMD_FILL_ASC) ? fill_pos
                                                                 : n - W'(1) - fill_pos;
                        ring_slots[fill_pos] = fill_id;
                        slot_of[fill_id]     = fill_pos;
                    end
                    front_idx = '0;
                    back_idx  = n;
                end
            end
        endcase
        if (res.ok && (cmd == dssq_pkg::CMD_TAKE_FRONT || cmd == dssq_pkg::CMD_TAKE_BACK))
        begin
            last_taken = res.element_out;
        end
        res.count     = back_idx - front_idx;
        res.empty_res = (res.count == '0);
    endtask

    task automatic send_command(input dssq_pkg::cmd_t cmd, input logic [W-1:0] id,
                                input logic [W-1:0] n);
        logic [dssq_pkg::S_TDATA_W-1:0] word;
        queue_result_t                  res;
        word = '0;
        word[dssq_pkg::IN_CMD_LSB  +: dssq_pkg::CMD_W] = cmd;
        word[dssq_pkg::IN_ELEM_LSB +: W]               = id;
        word[dssq_pkg::IN_FILL_LSB +: W]               = n;
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        apply_queue_command(cmd, id, n, res);
        pending_results.push_back(res);
        commands_sent++;
    endtask

    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending_results.size() != 0);
    endtask

    always @(posedge aclk) begin : result_monitor
        queue_result_t want;
        queue_result_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got.ok          = m_tdata[dssq_pkg::OUT_OK_BIT];
            got.element_out = m_tdata[dssq_pkg::OUT_ELEM_LSB +: W];
            got.count       = m_tdata[dssq_pkg::OUT_COUNT_LSB +: W];
            got.empty_res   = m_tdata[dssq_pkg::OUT_EMPTY_BIT];
            got.range_error = m_tdata[dssq_pkg::OUT_ERR_BIT];
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result", m_tdata, 0);
            end else begin
                want = pending_results.pop_front();
                if (got.ok !== want.ok)
                    report_mismatch("ok", got.ok, want.ok);
                if (got.element_out !== want.element_out)
                    report_mismatch("element_out", got.element_out, want.element_out);
                if (got.count !== want.count)
                    report_mismatch("count", got.count, want.count);
                if (got.empty_res !== want.empty_res)
                    report_mismatch("empty_res", got.empty_res, want.empty_res);
                if (got.range_error !== want.range_error)
                    report_mismatch("range_error", got.range_error, want.range_error);
                if (want.ok)
                    ok_results++;
                if (want.range_error)
                    range_errors++;
            end
            results_checked++;
        end
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    task automatic test_empty_queue();
        send_command(dssq_pkg::CMD_TAKE_FRONT, '0, '0);
        send_command(dssq_pkg::CMD_TAKE_BACK, '0, '0);
        send_command(dssq_pkg::CMD_CLEAR, '0, '0);
    endtask

    task automatic test_range_errors();
        send_command(dssq_pkg::CMD_ADD, '1, '0);
        send_command(dssq_pkg::CMD_REMOVE, '1, '0);
        send_command(dssq_pkg::CMD_QUERY, '1, '0);
        send_command(dssq_pkg::CMD_FILL_ASC, '0, '1);
        send_command(dssq_pkg::CMD_FILL_DESC, '0, '1);
    endtask

    task automatic test_full_ring_wrap();
        send_command(dssq_pkg::CMD_FILL_ASC, '0, dssq_pkg::ID_MAX);
        send_command(dssq_pkg::CMD_ADD, dssq_pkg::ID_MAX, '0);
        send_command(dssq_pkg::CMD_ADD, '0, '0);
        send_command(dssq_pkg::CMD_TAKE_FRONT, '0, '0);
        send_command(dssq_pkg::CMD_ADD, '0, '0);
        send_command(dssq_pkg::CMD_QUERY, '0, '0);
        send_command(dssq_pkg::CMD_REMOVE, W'(5), '0);
        send_command(dssq_pkg::CMD_QUERY, '0, '0);
        send_command(dssq_pkg::CMD_QUERY, W'(5), '0);
        send_command(dssq_pkg::CMD_TAKE_BACK, '0, '0);
    endtask

    task automatic test_descending_fill();
        send_command(dssq_pkg::CMD_FILL_DESC, '0, '0);
        send_command(dssq_pkg::CMD_TAKE_FRONT, '0, '0);
        send_command(dssq_pkg::CMD_FILL_DESC, '0, W'(8));
        send_command(dssq_pkg::CMD_TAKE_FRONT, '0, '0);
        send_command(dssq_pkg::CMD_TAKE_BACK, '0, '0);
        send_command(dssq_pkg::CMD_REMOVE, W'(3), '0);
        send_command(dssq_pkg::CMD_QUERY, W'(4), '0);
        send_command(dssq_pkg::CMD_CLEAR, '0, '0);
        send_command(dssq_pkg::CMD_FILL_ASC, '0, W'(1));
    endtask

    function automatic logic [W-1:0] pick_element();
        return ($urandom_range(1) != 0) ? W'($urandom_range(31))
                                        : W'($urandom_range(510));
    endfunction

    task automatic run_traffic_phase(input int idle_pct, input int stall, input int items);
        int             start_count;
        int             r;
        dssq_pkg::cmd_t fill_cmd;
        send_idle_pct = idle_pct;
        stall_pct     = stall;
        start_count   = commands_sent;
        while (commands_sent - start_count < items) begin
            r        = $urandom_range(99);
            fill_cmd = ($urandom_range(1) != 0) ? dssq_pkg::CMD_FILL_ASC
                                                : dssq_pkg::CMD_FILL_DESC;
            if (r < 25) begin
                send_command(dssq_pkg::CMD_ADD, pick_element(), W'($urandom));
            end else if (r < 37) begin
                send_command(dssq_pkg::CMD_REMOVE, pick_element(), W'($urandom));
            end else if (r < 49) begin
                send_command(dssq_pkg::CMD_QUERY, pick_element(), W'($urandom));
            end else if (r < 59) begin
                send_command(dssq_pkg::CMD_TAKE_FRONT, W'($urandom), W'($urandom));
            end else if (r < 66) begin
                send_command(dssq_pkg::CMD_TAKE_BACK, W'($urandom), W'($urandom));
            end else if (r < 81) begin
                // rotate the worklist: hand the front id back at the tail
                send_command(dssq_pkg::CMD_TAKE_FRONT, W'($urandom), W'($urandom));
                send_command(dssq_pkg::CMD_ADD, last_taken, W'($urandom));
            end else if (r < 83) begin
                send_command(dssq_pkg::CMD_CLEAR, W'($urandom), W'($urandom));
            end else if (r < 91) begin
                send_command(fill_cmd, W'($urandom), W'($urandom_range(24)));
            end else if (r < 96) begin
                send_command(fill_cmd, W'($urandom), W'($urandom_range(400, 510)));
            end else begin
                send_command(dssq_pkg::cmd_t'($urandom_range(7)), '1, '1);
            end
        end
        wait_for_results();
    endtask

    task automatic test_random_traffic();
        run_traffic_phase(0, 0, 235);
        run_traffic_phase(67, 0, 235);
        run_traffic_phase(0, 67, 235);
        run_traffic_phase(7, 7, 235);
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);
        test_empty_queue();
        test_range_errors();
        test_full_ring_wrap();
        test_descending_fill();
        wait_for_results();
        test_random_traffic();
        repeat (20) @(posedge aclk);
        $display("Summary: %0d commands over four pacing phases, %0d results checked",
                 commands_sent, results_checked);
        $display("Summary: %0d successful results, %0d range errors, %0d mismatches",
                 ok_results, range_errors, error_count);
        if (error_count == 0 && pending_results.size() == 0) begin
            $display("dedup_sparse_set_work_queue_unit verification clean");
        end else begin
            $display("dedup_sparse_set_work_queue_unit verification failed");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Timeout with %0d results outstanding", pending_results.size());
        $display("dedup_sparse_set_work_queue_unit verification failed");
        $finish;
    end

endmodule
